/* hdl/samf_pkg.sv */
// Shared types and constants for the six-axis moving average filter.
package samf_pkg;

  // Default sizes of the filter.
  localparam int WINDOW_DEF      = 50;
  localparam int CHANNELS_DEF    = 6;
  localparam int SAMPLE_BITS_DEF = 16;

  // Fixed layout of one beat: three forces, then three torques.
  localparam int NUM_FIELDS  = 6;
  localparam int Z_CHANNEL   = 2;
  localparam int OFFSET_BITS = 16;

  // Pipeline controls that the sequencer hands to every lane.
  typedef struct packed {
    logic a_load;   // A new beat enters stage A.
    logic a_go;     // Stage A moves on to stage B; state is updated here.
    logic b_go;     // Stage B moves on to stage C.
    logic c_go;     // Stage C moves into the output register.
    logic a_prime;  // The beat in stage A is the first one after reset.
    logic a_first;  // The oldest slot of the beat in stage A still holds the first sample.
  } samf_ctrl_t;

endpackage

/* hdl/samf_ctrl.sv */
// Handshake sequencer and ring position tracking shared by all lanes.
module samf_ctrl #(
  parameter int WINDOW = 50
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  output logic                       out_valid,
  input  logic                       out_stall,
  output samf_pkg::samf_ctrl_t       ctrl,
  output logic [$clog2(WINDOW)-1:0]  rd_slot,
  output logic [$clog2(WINDOW)-1:0]  a_slot
);
  import samf_pkg::*;

  localparam int SLOT_W = $clog2(WINDOW);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);

  logic              a_valid_r, a_valid_nxt;
  logic              b_valid_r, b_valid_nxt;
  logic              c_valid_r, c_valid_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [SLOT_W-1:0] oldest_r, oldest_nxt;
  logic              primed_r, primed_nxt;
  logic              lap_r, lap_nxt;
  logic [SLOT_W-1:0] a_slot_r, a_slot_nxt;
  logic              a_prime_r, a_prime_nxt;
  logic              a_first_r, a_first_nxt;
  logic              out_free, c_free, b_free, a_free;
  logic              a_load, a_go, b_go, c_go;

  // Each stage moves when the one after it is empty or moving.
  always_comb begin
    out_free = !out_valid_r || !out_stall;
    c_go     = c_valid_r && out_free;
    c_free   = !c_valid_r || out_free;
    b_go     = b_valid_r && c_free;
    b_free   = !b_valid_r || c_free;
    a_go     = a_valid_r && b_free;
    a_free   = !a_valid_r || b_free;
    a_load   = in_valid && a_free;
  end

  // Stage occupancy.
  always_comb begin
    a_valid_nxt   = a_load || (a_valid_r && !a_go);
    b_valid_nxt   = a_go || (b_valid_r && !b_go);
    c_valid_nxt   = b_go || (c_valid_r && !c_go);
    out_valid_nxt = c_go || (out_valid_r && out_stall);
  end

  // Ring position. The first beat after reset stands for the whole window, so
  // during the first lap every slot read is taken as that first sample.
  always_comb begin
    oldest_nxt  = oldest_r;
    primed_nxt  = primed_r;
    lap_nxt     = lap_r;
    a_slot_nxt  = a_slot_r;
    a_prime_nxt = a_prime_r;
    a_first_nxt = a_first_r;
    if (a_load) begin
      if (!primed_r) begin
        primed_nxt  = 1'b1;
        a_prime_nxt = 1'b1;
        a_first_nxt = 1'b1;
        a_slot_nxt  = '0;
      end else begin
        a_prime_nxt = 1'b0;
        a_first_nxt = !lap_r;
        a_slot_nxt  = oldest_r;
        if (oldest_r == LAST_SLOT) begin
          oldest_nxt = '0;
          lap_nxt    = 1'b1;
        end else begin
          oldest_nxt = oldest_r + SLOT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      c_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      oldest_r    <= '0;
      primed_r    <= 1'b0;
      lap_r       <= 1'b0;
      a_slot_r    <= '0;
      a_prime_r   <= 1'b0;
      a_first_r   <= 1'b0;
    end else begin
      a_valid_r   <= a_valid_nxt;
      b_valid_r   <= b_valid_nxt;
      c_valid_r   <= c_valid_nxt;
      out_valid_r <= out_valid_nxt;
      oldest_r    <= oldest_nxt;
      primed_r    <= primed_nxt;
      lap_r       <= lap_nxt;
      a_slot_r    <= a_slot_nxt;
      a_prime_r   <= a_prime_nxt;
      a_first_r   <= a_first_nxt;
    end
  end

  // Outputs to the lanes and the ports.
  always_comb begin
    ctrl.a_load  = a_load;
    ctrl.a_go    = a_go;
    ctrl.b_go    = b_go;
    ctrl.c_go    = c_go;
    ctrl.a_prime = a_prime_r;
    ctrl.a_first = a_first_r;
  end

  assign in_stall  = !a_free;
  assign out_valid = out_valid_r;
  assign rd_slot   = oldest_r;
  assign a_slot    = a_slot_r;

endmodule

/* hdl/samf_lane.sv */
// One channel: sample ring, running sum and division by the window length.
module samf_lane #(
  parameter int WINDOW      = 50,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  samf_pkg::samf_ctrl_t          ctrl,
  input  logic [$clog2(WINDOW)-1:0]     rd_slot,
  input  logic [$clog2(WINDOW)-1:0]     a_slot,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output logic [SAMPLE_BITS-1:0]        quot,
  output logic                          neg
);
  import samf_pkg::*;

  localparam int SLOT_W  = $clog2(WINDOW);
  localparam int SUM_W   = SAMPLE_BITS + SLOT_W;
  localparam int K       = SUM_W + SLOT_W;
  localparam int RECIP_W = K - SLOT_W + 2;
  localparam int PROD_W  = SUM_W + RECIP_W;
  // Rounded-up reciprocal; exact floor division for every sum magnitude.
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << K) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
  localparam logic signed [SUM_W-1:0] WIN_S = SUM_W'(WINDOW);

  logic [SAMPLE_BITS-1:0]        ring [WINDOW];
  logic [SAMPLE_BITS-1:0]        rd_q_r;
  logic signed [SAMPLE_BITS-1:0] x_a_r;
  logic signed [SAMPLE_BITS-1:0] first_r;
  logic signed [SUM_W-1:0]       sum_r, sum_nxt;
  logic signed [SUM_W-1:0]       sum_b_r;
  logic [PROD_W-1:0]             prod_c_r;
  logic                          neg_c_r;
  logic signed [SAMPLE_BITS-1:0] old_val;
  logic [SUM_W-1:0]              mag_b;

  // Ring memory: read the oldest slot as a beat enters, write it as it leaves.
  always_ff @(posedge clk) begin
    if (ctrl.a_load) begin
      rd_q_r <= ring[rd_slot];
    end
    if (ctrl.a_go && !ctrl.a_prime) begin
      ring[a_slot] <= x_a_r;
    end
  end

  // Stage A input register and the first sample after reset.
  always_ff @(posedge clk) begin
    if (ctrl.a_load) begin
      x_a_r <= sample;
    end
    if (ctrl.a_go && ctrl.a_prime) begin
      first_r <= x_a_r;
    end
  end

  // Running sum update.
  always_comb begin
    old_val = ctrl.a_first ? first_r : $signed(rd_q_r);
    if (ctrl.a_prime) begin
      sum_nxt = SUM_W'(x_a_r) * WIN_S;
    end else begin
      sum_nxt = sum_r - SUM_W'(old_val) + SUM_W'(x_a_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (ctrl.a_go) begin
      sum_r <= sum_nxt;
    end
  end

  // Stage B holds the sum; stage C holds magnitude times reciprocal.
  assign mag_b = sum_b_r[SUM_W-1] ? (SUM_W'(0) - SUM_W'(sum_b_r)) : SUM_W'(sum_b_r);

  always_ff @(posedge clk) begin
    if (ctrl.a_go) begin
      sum_b_r <= sum_nxt;
    end
    if (ctrl.b_go) begin
      prod_c_r <= PROD_W'(mag_b) * PROD_W'(RECIP);
      neg_c_r  <= sum_b_r[SUM_W-1];
    end
  end

  assign quot = prod_c_r[K +: SAMPLE_BITS];
  assign neg  = neg_c_r;

endmodule

/* hdl/samf_merge.sv */
// Merge of the lane quotients into one result beat, with the weight offset on z.
module samf_merge #(
  parameter int CHANNELS    = 6,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  samf_pkg::samf_ctrl_t                ctrl,
  input  logic [SAMPLE_BITS-1:0]              lane_quot [samf_pkg::NUM_FIELDS],
  input  logic                                lane_neg  [samf_pkg::NUM_FIELDS],
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic signed [samf_pkg::OFFSET_BITS-1:0] cfg_weight_offset,
  output logic signed [SAMPLE_BITS-1:0]       out_avg_force_x,
  output logic signed [SAMPLE_BITS-1:0]       out_avg_force_y,
  output logic signed [SAMPLE_BITS:0]         out_avg_force_z,
  output logic signed [SAMPLE_BITS-1:0]       out_avg_torque_x,
  output logic signed [SAMPLE_BITS-1:0]       out_avg_torque_y,
  output logic signed [SAMPLE_BITS-1:0]       out_avg_torque_z
);
  import samf_pkg::*;

  localparam int DIFF_W = ((SAMPLE_BITS > OFFSET_BITS) ? SAMPLE_BITS : OFFSET_BITS) + 1;

  logic signed [OFFSET_BITS-1:0] offset_r;
  logic [SAMPLE_BITS-1:0]        avg      [NUM_FIELDS];
  logic [SAMPLE_BITS-1:0]        avg_r    [NUM_FIELDS];
  logic signed [DIFF_W-1:0]      diff_z;
  logic [SAMPLE_BITS:0]          z_val;
  logic [SAMPLE_BITS:0]          z_r;

  // The weight offset register accepts a write in any cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
    end else if (cfg_valid) begin
      offset_r <= cfg_weight_offset;
    end
  end

  // Apply the sign to each truncated quotient.
  always_comb begin
    for (int f = 0; f < NUM_FIELDS; f++) begin
      avg[f] = lane_neg[f] ? (SAMPLE_BITS'(0) - lane_quot[f]) : lane_quot[f];
    end
  end

  // Vertical force minus the weight offset, one bit wider than a sample.
  always_comb begin
    diff_z = DIFF_W'($signed(avg[Z_CHANNEL])) - DIFF_W'(offset_r);
    z_val  = (Z_CHANNEL < CHANNELS) ? diff_z[SAMPLE_BITS:0] : '0;
  end

  // Output register, loaded as a result beat leaves stage C.
  always_ff @(posedge clk) begin
    if (ctrl.c_go) begin
      for (int f = 0; f < NUM_FIELDS; f++) begin
        avg_r[f] <= avg[f];
      end
      z_r <= z_val;
    end
  end

  assign out_avg_force_x  = $signed(avg_r[0]);
  assign out_avg_force_y  = $signed(avg_r[1]);
  assign out_avg_force_z  = $signed(z_r);
  assign out_avg_torque_x = $signed(avg_r[3]);
  assign out_avg_torque_y = $signed(avg_r[4]);
  assign out_avg_torque_z = $signed(avg_r[5]);

endmodule

/* hdl/six_axis_moving_average_top.sv */
// Top level of the six-axis force/torque moving average filter.
//
// Input channel: in_valid/in_stall carry one six-axis sample per beat.
// Result channel: out_valid/out_stall carry the six window averages per beat,
// sum over the last WINDOW samples divided by WINDOW, truncated toward zero;
// the z force average has the weight offset subtracted and is one bit wider.
// Configuration: cfg_valid/cfg_ready write the weight offset; cfg_ready is
// always high. Write it only while no beat is in flight.
// Each beat passes stages A, B and C into the output register for out_valid;
// one beat is taken every cycle while in_stall is low, set by the one read and
// one write per cycle of each lane's ring memory and the sum every beat updates.
// Each channel has its own lane; the lanes run in lockstep through an input
// stage with the ring read, a sum stage, a reciprocal multiply stage and the
// shared output register. The first beat after reset stands for a full window,
// so its result equals the sample. Reset clears the running sums, the ring
// position, the offset and all valid bits; no clearing pass is needed.
// When the receiver stalls, the result holds and earlier stages keep filling;
// in_stall rises only once every stage is occupied.
module six_axis_moving_average_top #(
  parameter int WINDOW      = samf_pkg::WINDOW_DEF,
  parameter int CHANNELS    = samf_pkg::CHANNELS_DEF,
  parameter int SAMPLE_BITS = samf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [SAMPLE_BITS-1:0]           in_force_x,
  input  logic signed [SAMPLE_BITS-1:0]           in_force_y,
  input  logic signed [SAMPLE_BITS-1:0]           in_force_z,
  input  logic signed [SAMPLE_BITS-1:0]           in_torque_x,
  input  logic signed [SAMPLE_BITS-1:0]           in_torque_y,
  input  logic signed [SAMPLE_BITS-1:0]           in_torque_z,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [SAMPLE_BITS-1:0]           out_avg_force_x,
  output logic signed [SAMPLE_BITS-1:0]           out_avg_force_y,
  output logic signed [SAMPLE_BITS:0]             out_avg_force_z,
  output logic signed [SAMPLE_BITS-1:0]           out_avg_torque_x,
  output logic signed [SAMPLE_BITS-1:0]           out_avg_torque_y,
  output logic signed [SAMPLE_BITS-1:0]           out_avg_torque_z,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic signed [samf_pkg::OFFSET_BITS-1:0] cfg_weight_offset
);
  import samf_pkg::*;

  localparam int SLOT_W = $clog2(WINDOW);

  samf_ctrl_t                    ctrl;
  logic [SLOT_W-1:0]             rd_slot;
  logic [SLOT_W-1:0]             a_slot;
  logic signed [SAMPLE_BITS-1:0] in_x      [NUM_FIELDS];
  logic [SAMPLE_BITS-1:0]        lane_quot [NUM_FIELDS];
  logic                          lane_neg  [NUM_FIELDS];

  // Sample fields in lane order.
  assign in_x[0] = in_force_x;
  assign in_x[1] = in_force_y;
  assign in_x[2] = in_force_z;
  assign in_x[3] = in_torque_x;
  assign in_x[4] = in_torque_y;
  assign in_x[5] = in_torque_z;

  samf_ctrl #(
    .WINDOW (WINDOW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctrl      (ctrl),
    .rd_slot   (rd_slot),
    .a_slot    (a_slot)
  );

  // One lane per present channel; absent channels read as zero.
  for (genvar c = 0; c < NUM_FIELDS; c++) begin : g_lane
    if (c < CHANNELS) begin : g_on
      samf_lane #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
      ) u_lane (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .rd_slot (rd_slot),
        .a_slot  (a_slot),
        .sample  (in_x[c]),
        .quot    (lane_quot[c]),
        .neg     (lane_neg[c])
      );
    end else begin : g_off
      assign lane_quot[c] = '0;
      assign lane_neg[c]  = 1'b0;
    end
  end

  samf_merge #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_merge (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctrl              (ctrl),
    .lane_quot         (lane_quot),
    .lane_neg          (lane_neg),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_weight_offset (cfg_weight_offset),
    .out_avg_force_x   (out_avg_force_x),
    .out_avg_force_y   (out_avg_force_y),
    .out_avg_force_z   (out_avg_force_z),
    .out_avg_torque_x  (out_avg_torque_x),
    .out_avg_torque_y  (out_avg_torque_y),
    .out_avg_torque_z  (out_avg_torque_z)
  );

endmodule
